[sv/tgr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgr_pkg
// Word types, register map, pixel formats and the 16-color text palette.
// ----------------------------------------------------------------------------
package tgr_pkg;

	localparam int GLYPH_HEIGHT = 16;
	localparam int GLYPH_WIDTH  = 8;
	localparam int PIX_W        = 24;
	localparam int SCAN_W       = 9;   // row * height + line, row and line at full width
	localparam int COLB_W       = 12;  // col * width * 4 at most
	localparam int PROD_W       = 25;  // scan * pitch

	localparam logic [7:0] CHAR_FIRST = 8'h20;
	localparam logic [7:0] CHAR_LAST  = 8'h7E;

	typedef enum logic [1:0] {
		REG_FRAME_BASE   = 2'd0,
		REG_LINE_PITCH   = 2'd1,
		REG_PIXEL_FORMAT = 2'd2,
		REG_NONE         = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		FMT_RGB32  = 2'd0,
		FMT_RGB24  = 2'd1,
		FMT_RGB565 = 2'd2,
		FMT_RGB555 = 2'd3
	} pix_fmt_t;

	localparam logic [PIX_W-1:0] CGA_PALETTE [16] = '{
		24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA,
		24'hAA0000, 24'hAA00AA, 24'hAA5500, 24'hAAAAAA,
		24'h555555, 24'h5555FF, 24'h55FF55, 24'h55FFFF,
		24'hFF5555, 24'hFF55FF, 24'hFFFF55, 24'hFFFFFF
	};

	typedef struct packed {
		logic [6:0] cell_col;
		logic [4:0] cell_row;
		logic [3:0] glyph_line;
		logic [7:0] char_code;
		logic [7:0] attribute;
		logic [7:0] glyph_bits;
	} in_word_t;

	typedef struct packed {
		logic [31:0]      row_address;
		logic [PIX_W-1:0] pixel_0;
		logic [PIX_W-1:0] pixel_1;
		logic [PIX_W-1:0] pixel_2;
		logic [PIX_W-1:0] pixel_3;
		logic [PIX_W-1:0] pixel_4;
		logic [PIX_W-1:0] pixel_5;
		logic [PIX_W-1:0] pixel_6;
		logic [PIX_W-1:0] pixel_7;
	} out_word_t;

	function automatic logic [PIX_W-1:0] pack_color(input logic [PIX_W-1:0] rgb,
		input pix_fmt_t fmt);
		logic [PIX_W-1:0] res;
		unique case (fmt)
			FMT_RGB32, FMT_RGB24: res = rgb;
			FMT_RGB565: res = {8'h00, rgb[23:19], rgb[15:10], rgb[7:3]};
			FMT_RGB555: res = {9'h000, rgb[23:19], rgb[15:11], rgb[7:3]};
			default: res = rgb;
		endcase
		return res;
	endfunction

endpackage

[sv/text_glyph_row_renderer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_glyph_row_renderer
// Renders one glyph row of a text cell: framebuffer address plus 8 packed pixels.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle unless out_ready stalls the pipe; stage 1 does
// lookups and base+column add, stage 2 the scan*pitch multiply and color packing,
// stage 3 the final add.
// Reset: valid bits clear, frame_base=0, line_pitch=2560, pixel_format=32bpp.
module text_glyph_row_renderer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  tgr_pkg::in_word_t in_word,
	output logic              out_valid,
	input  logic              out_ready,
	output tgr_pkg::out_word_t out_word,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import tgr_pkg::*;

	// configuration registers
	logic [31:0] frame_base_q;
	logic [15:0] line_pitch_q;
	pix_fmt_t    pixel_format_q;
	reg_idx_t    reg_idx;
	logic        cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_base_q   <= '0;
			line_pitch_q   <= 16'd2560;
			pixel_format_q <= FMT_RGB32;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_FRAME_BASE:   frame_base_q   <= pwdata;
				REG_LINE_PITCH:   line_pitch_q   <= pwdata[15:0];
				REG_PIXEL_FORMAT: pixel_format_q <= pix_fmt_t'(pwdata[1:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_FRAME_BASE:   prdata = frame_base_q;
			REG_LINE_PITCH:   prdata = {16'h0000, line_pitch_q};
			REG_PIXEL_FORMAT: prdata = {30'h0, pixel_format_q};
			default:          prdata = '0;
		endcase
	end

	// pipeline flow control
	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;

	assign en3      = !v_s3 || out_ready;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;
	assign out_valid = v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	// stage 1: scanline, column offset, palette lookup, printable mask
	logic              printable;
	logic [SCAN_W-1:0] scan;
	logic [9:0]        col_px;
	logic [COLB_W-1:0] col_bytes;

	assign printable = (in_word.char_code >= CHAR_FIRST) && (in_word.char_code <= CHAR_LAST);
	assign scan      = SCAN_W'(in_word.cell_row) * SCAN_W'(GLYPH_HEIGHT)
		+ SCAN_W'(in_word.glyph_line);
	assign col_px    = 10'(in_word.cell_col) * 10'(GLYPH_WIDTH);

	always_comb begin
		unique case (pixel_format_q)
			FMT_RGB32: col_bytes = {col_px, 2'b00};
			FMT_RGB24: col_bytes = {1'b0, col_px, 1'b0} + {2'b00, col_px};
			FMT_RGB565, FMT_RGB555: col_bytes = {1'b0, col_px, 1'b0};
			default: col_bytes = {col_px, 2'b00};
		endcase
	end

	logic [SCAN_W-1:0] scan_s1;
	logic [31:0]       base_col_s1;
	logic [PIX_W-1:0]  fg_rgb_s1, bg_rgb_s1;
	logic [7:0]        bits_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			scan_s1     <= scan;
			base_col_s1 <= frame_base_q + 32'(col_bytes);
			fg_rgb_s1   <= CGA_PALETTE[in_word.attribute[3:0]];
			bg_rgb_s1   <= CGA_PALETTE[in_word.attribute[7:4]];
			bits_s1     <= printable ? in_word.glyph_bits : 8'h00;
		end
	end

	// stage 2: scan * pitch, color packing
	logic [PROD_W-1:0] prod_s2;
	logic [31:0]       base_col_s2;
	logic [PIX_W-1:0]  fg_s2, bg_s2;
	logic [7:0]        bits_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			prod_s2     <= PROD_W'(scan_s1) * PROD_W'(line_pitch_q);
			base_col_s2 <= base_col_s1;
			fg_s2       <= pack_color(fg_rgb_s1, pixel_format_q);
			bg_s2       <= pack_color(bg_rgb_s1, pixel_format_q);
			bits_s2     <= bits_s1;
		end
	end

	// stage 3: final address add and pixel select (output register)
	logic [PIX_W-1:0] pix [8];

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			pix[i] = bits_s2[7-i] ? fg_s2 : bg_s2;  // MSB is leftmost
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			out_word.row_address <= base_col_s2 + 32'(prod_s2);
			out_word.pixel_0     <= pix[0];
			out_word.pixel_1     <= pix[1];
			out_word.pixel_2     <= pix[2];
			out_word.pixel_3     <= pix[3];
			out_word.pixel_4     <= pix[4];
			out_word.pixel_5     <= pix[5];
			out_word.pixel_6     <= pix[6];
			out_word.pixel_7     <= pix[7];
		end
	end

`ifndef SYNTH
	// a stalled stage 2 word is kept intact
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !en3 |=> v_s2 && $stable(prod_s2) && $stable(fg_s2) && $stable(bits_s2))
		else $error("stage 2 word lost or altered under stall");

	// the pipe never throttles the input when the output drains
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output is draining");

	// 15/16 bpp colors keep the top byte clear
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (pixel_format_q == FMT_RGB565 || pixel_format_q == FMT_RGB555)
		|-> out_word.pixel_0[23:16] == 8'h00 && out_word.pixel_7[23:16] == 8'h00)
		else $error("packed 16-bit pixel has high bits set");

	// 32bpp with aligned base and pitch gives aligned row addresses
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pixel_format_q == FMT_RGB32 && frame_base_q[1:0] == 2'b00
		&& line_pitch_q[1:0] == 2'b00 |-> out_word.row_address[1:0] == 2'b00)
		else $error("misaligned 32bpp row address");
`endif

endmodule
